[design/mbds_pkg.sv]
// ----------------------------------------------------------------------------
// mbds_pkg: shared types and constants of the delimiter splitter
// Beat, configuration and result types, field widths and register indexes.
// ----------------------------------------------------------------------------
package mbds_pkg;

  // limits of the splitter
  localparam int DELIM_MAX = 8;
  localparam int MAX_BYTES = 65536;

  // field widths
  localparam int BYTE_W    = 8;
  localparam int DELIM_W   = 64;
  localparam int LEN_W     = 4;
  localparam int SEG_W     = 16;
  localparam int POS_W     = $clog2(MAX_BYTES + 1);
  localparam int OUT_DW    = 72;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_BYTES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEGS    = 2'd2;

  // register reset values
  localparam logic [DELIM_W-1:0] DELIM_BYTES_RST = '0;
  localparam logic [LEN_W-1:0]   DELIM_LEN_RST   = 4'd1;
  localparam logic [SEG_W-1:0]   MAX_SEGS_RST    = 16'hFFFF;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;
  } beat_t;

  typedef struct packed {
    logic [DELIM_W-1:0] delim_bytes;
    logic [LEN_W-1:0]   delim_len;
    logic [SEG_W-1:0]   max_segs;
  } cfg_t;

  typedef struct packed {
    logic             segment_valid;
    logic [SEG_W-1:0] segment_index;
    logic [SEG_W-1:0] segment_start;
    logic [POS_W-1:0] segment_end;
    logic             done_res;
    logic             failed;
    logic [SEG_W-1:0] segment_count;
  } result_t;

  // delimiter length in use: zero counts as one, clamp at the maximum
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
    logic [LEN_W-1:0] len;
    len = raw;
    if (len == '0) len = LEN_W'(1);
    if (len > LEN_W'(DELIM_MAX)) len = LEN_W'(DELIM_MAX);
    return len;
  endfunction

  // mask covering the low len bytes of the delimiter word
  function automatic logic [DELIM_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DELIM_W-1:0] m;
    m = '0;
    for (int k = 0; k < DELIM_MAX; k++) begin
      if (LEN_W'(k) < len) m[k*BYTE_W +: BYTE_W] = '1;
    end
    return m;
  endfunction

endpackage

[design/mbds_in_stage.sv]
// ----------------------------------------------------------------------------
// mbds_in_stage: input register of the splitter
// Holds one input beat until the core takes it; refills in the same cycle.
// ----------------------------------------------------------------------------
module mbds_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  mbds_pkg::beat_t in_beat,
  input  logic          take,
  output logic          beat_valid,
  output mbds_pkg::beat_t beat
);
  import mbds_pkg::*;

  logic  valid_r;
  beat_t beat_r;

  // free when empty or when the held beat leaves this cycle
  assign in_tready  = !valid_r || take;
  assign beat_valid = valid_r;
  assign beat       = beat_r;

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      beat_r <= in_beat;
    end
  end

endmodule

[design/mbds_core.sv]
// ----------------------------------------------------------------------------
// mbds_core: window match, segment bookkeeping and result register
// One beat per cycle unless the result stalls: shifts the byte into the match
// window, compares the newest bytes against the delimiter and closes segments.
// ----------------------------------------------------------------------------
module mbds_core (
  input  logic              clk,
  input  logic              rst_n,
  input  mbds_pkg::cfg_t    cfg,
  input  logic              beat_valid,
  input  mbds_pkg::beat_t   beat,
  output logic              take,
  output logic              res_valid,
  input  logic              res_ready,
  output mbds_pkg::result_t res
);
  import mbds_pkg::*;

  // per-buffer state
  logic [DELIM_W-1:0] win_r,   win_nxt;
  logic [LEN_W-1:0]   bsc_r,   bsc_nxt;
  logic [POS_W-1:0]   pos_r,   pos_nxt;
  logic [POS_W-1:0]   start_r, start_nxt;
  logic [SEG_W-1:0]   segs_r,  segs_nxt;
  logic               ovf_r,   ovf_nxt;

  logic               res_valid_r;
  result_t            res_r, res_nxt;

  logic [LEN_W-1:0]   dlen;
  logic               overrun;
  logic [DELIM_W-1:0] win_shift;
  logic [LEN_W-1:0]   bsc_inc;
  logic [5:0]         shamt;
  logic [DELIM_W-1:0] tail;
  logic [DELIM_W-1:0] mask;
  logic               hit;
  logic [LEN_W-1:0]   bsc_upd;
  logic [POS_W-1:0]   pos_upd;
  logic               tail_open;
  logic               tail_seg;
  logic               seg;
  logic               emit;

  // beat leaves the input stage when the result register can take it
  assign take      = beat_valid && (!res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  // window compare
  assign dlen      = eff_len(cfg.delim_len);
  assign overrun   = (pos_r >= POS_W'(MAX_BYTES)) || (segs_r >= cfg.max_segs);
  assign win_shift = {beat.data_byte, win_r[DELIM_W-1:BYTE_W]};
  assign bsc_inc   = (bsc_r < LEN_W'(DELIM_MAX)) ? bsc_r + LEN_W'(1) : bsc_r;
  assign shamt     = {3'((LEN_W'(DELIM_MAX) - dlen)), 3'b000};
  assign tail      = win_shift >> shamt;
  assign mask      = byte_mask(dlen);
  assign hit       = !overrun && (bsc_inc >= dlen)
                     && ((tail & mask) == (cfg.delim_bytes & mask));

  // position and cut counter after this byte
  assign bsc_upd   = overrun ? bsc_r : (hit ? '0 : bsc_inc);
  assign pos_upd   = overrun ? pos_r : pos_r + POS_W'(1);

  // last byte closes any open segment, if the limit allows
  assign tail_open = beat.is_last && !hit && (bsc_upd != '0);
  assign tail_seg  = tail_open && (segs_r < cfg.max_segs);
  assign seg       = hit || tail_seg;
  assign emit      = seg || beat.is_last;

  // next state and result
  always_comb begin
    win_nxt   = win_r;
    bsc_nxt   = bsc_upd;
    pos_nxt   = pos_upd;
    start_nxt = start_r;
    segs_nxt  = segs_r + SEG_W'(seg);
    ovf_nxt   = ovf_r || overrun || (tail_open && !tail_seg);
    if (!overrun) begin
      win_nxt = hit ? '0 : win_shift;
      if (hit) start_nxt = pos_r + POS_W'(1);
    end

    res_nxt = '0;
    if (seg) begin
      res_nxt.segment_valid = 1'b1;
      res_nxt.segment_index = segs_r;
      res_nxt.segment_start = start_r[SEG_W-1:0];
      res_nxt.segment_end   = hit ? pos_r + POS_W'(1) - POS_W'(dlen) : pos_upd;
    end
    if (beat.is_last) begin
      res_nxt.done_res      = 1'b1;
      res_nxt.failed        = ovf_nxt;
      res_nxt.segment_count = segs_nxt;
      win_nxt   = '0;
      bsc_nxt   = '0;
      pos_nxt   = '0;
      start_nxt = '0;
      segs_nxt  = '0;
      ovf_nxt   = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r   <= '0;
      bsc_r   <= '0;
      pos_r   <= '0;
      start_r <= '0;
      segs_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (take) begin
      win_r   <= win_nxt;
      bsc_r   <= bsc_nxt;
      pos_r   <= pos_nxt;
      start_r <= start_nxt;
      segs_r  <= segs_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (take) begin
      res_valid_r <= emit;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

[design/multi_byte_delimiter_splitter.sv]
// ----------------------------------------------------------------------------
// multi_byte_delimiter_splitter: cuts a byte stream at a 1 to 8 byte delimiter
//
//   channel  dir  beat content
//   in_*     in   one byte of the buffer, tlast on the final byte
//   out_*    out  closed segment (tuser) and/or buffer summary (tlast)
//   cfg_*    in   register write: delimiter bytes, length, segment limit
//
// One byte per cycle unless the result stalls; a byte passes first through
// the input register and then through the window compare into the result
// register. Reset clears the configuration to its defaults and the buffer
// state. A stalled result holds the byte behind it in the input register.
// ----------------------------------------------------------------------------
module multi_byte_delimiter_splitter (
  input  logic                            clk,
  input  logic                            rst_n,
  // input stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mbds_pkg::BYTE_W-1:0]     in_tdata,   // data_byte
  input  logic                            in_tlast,   // is_last
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // segment_index, segment_start, segment_end, failed, segment_count, zeros
  output logic [mbds_pkg::OUT_DW-1:0]     out_tdata,
  output logic                            out_tuser,  // segment_valid
  output logic                            out_tlast,  // done_res
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mbds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbds_pkg::DELIM_W-1:0]    cfg_wdata
);
  import mbds_pkg::*;

  cfg_t    cfg_r;
  beat_t   in_beat;
  beat_t   beat;
  logic    beat_valid;
  logic    take;
  result_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delim_bytes <= DELIM_BYTES_RST;
      cfg_r.delim_len   <= DELIM_LEN_RST;
      cfg_r.max_segs    <= MAX_SEGS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELIM_BYTES: cfg_r.delim_bytes <= cfg_wdata;
        CFG_DELIM_LEN:   cfg_r.delim_len   <= cfg_wdata[LEN_W-1:0];
        CFG_MAX_SEGS:    cfg_r.max_segs    <= cfg_wdata[SEG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_beat.data_byte = in_tdata;
  assign in_beat.is_last   = in_tlast;

  mbds_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_beat    (in_beat),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  mbds_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .beat_valid (beat_valid),
    .beat       (beat),
    .take       (take),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  // result beat packing
  assign out_tuser = res.segment_valid;
  assign out_tlast = res.done_res;
  assign out_tdata = {6'b0, res.segment_count, res.failed, res.segment_end,
                      res.segment_start, res.segment_index};

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for multi_byte_delimiter_splitter
// Drives byte buffers with random gaps against a stalling result side and
// checks every result beat against a cycle-free model of the splitter.
// A short directed table comes first, then random delimiter settings with
// mostly well-formed buffers, part of them sent with no idle cycles.
// ----------------------------------------------------------------------------
module testbench;
  import mbds_pkg::*;

  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int IDLE_PCT     = 21;
  localparam int RANDOM_BEATS = 1650;
  localparam int GAPLESS_FROM = 500;
  localparam int GAPLESS_TO   = 900;

  typedef struct {
    bit                   is_write;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [DELIM_W-1:0]   wdata;
    logic [BYTE_W-1:0]    data;
    bit                   last;
    bit                   typed;
    result_t              want;
  } plan_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata = '0;
  logic                 in_tlast = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_DW-1:0]    out_tdata;
  logic                 out_tuser;
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELIM_W-1:0]   cfg_wdata = '0;

  // splitter model: registers and per-buffer state
  logic [DELIM_W-1:0]   delim_word;
  logic [LEN_W-1:0]     delim_len_reg;
  logic [SEG_W-1:0]     seg_limit;
  logic [63:0]          window;
  int                   since_cut;
  int                   next_pos;
  int                   open_start;
  int                   closed_count;
  logic                 overrun;

  result_t              segments_due[$];
  logic [BYTE_W-1:0]    pending_bytes[$];
  int                   fail_count = 0;
  int                   beats_sent = 0;
  bit                   no_gaps = 1'b0;

  always #1 clk = ~clk;

  multi_byte_delimiter_splitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  function automatic void reset_buffer_state();
    window       = '0;
    since_cut    = 0;
    next_pos     = 0;
    open_start   = 0;
    closed_count = 0;
    overrun      = 1'b0;
  endfunction

  // zero length counts as one, long values clamp
  function automatic int delim_len_used();
    int n;
    n = int'(delim_len_reg);
    if (n < 1) n = 1;
    if (n > DELIM_MAX) n = DELIM_MAX;
    if (n > 8) n = 8;
    return n;
  endfunction

  // one byte into the model; returns 1 when the byte yields a result
  function automatic bit predict_segment(input logic [BYTE_W-1:0] b, input logic l,
                                         output result_t r);
    int          len;
    int          p;
    bit          seg;
    logic [63:0] mask;
    logic [63:0] tail;
    len = delim_len_used();
    p   = next_pos;
    seg = 1'b0;
    r   = '0;
    if (p >= MAX_BYTES || closed_count >= int'(seg_limit)) begin
      overrun = 1'b1;
    end else begin
      window = {b, window[63:8]};
      if (since_cut < 8) since_cut++;
      if (since_cut >= len) begin
        mask = (len == 8) ? '1 : ((64'd1 << (8 * len)) - 64'd1);
        tail = window >> (8 * (8 - len));
        if ((tail & mask) == (delim_word & mask)) begin
          seg             = 1'b1;
          r.segment_valid = 1'b1;
          r.segment_index = SEG_W'(closed_count);
          r.segment_start = SEG_W'(open_start);
          r.segment_end   = POS_W'(p + 1 - len);
          closed_count++;
          open_start = p + 1;
          since_cut  = 0;
          window     = '0;
        end
      end
      next_pos = p + 1;
    end
    // last byte closes whatever is open
    if (l && !seg && since_cut > 0) begin
      if (closed_count < int'(seg_limit)) begin
        seg             = 1'b1;
        r.segment_valid = 1'b1;
        r.segment_index = SEG_W'(closed_count);
        r.segment_start = SEG_W'(open_start);
        r.segment_end   = POS_W'(next_pos);
        closed_count++;
      end else begin
        overrun = 1'b1;
      end
    end
    if (!seg && !l) return 1'b0;
    if (l) begin
      r.done_res      = 1'b1;
      r.failed        = overrun;
      r.segment_count = SEG_W'(closed_count);
      reset_buffer_state();
    end
    return 1'b1;
  endfunction

  function automatic result_t make_res(bit sv, int si, int ss, int se, bit dn, bit fl, int sc);
    result_t r;
    r.segment_valid = sv;
    r.segment_index = SEG_W'(si);
    r.segment_start = SEG_W'(ss);
    r.segment_end   = POS_W'(se);
    r.done_res      = dn;
    r.failed        = fl;
    r.segment_count = SEG_W'(sc);
    return r;
  endfunction

  function automatic plan_row_t row_write(logic [CFG_IDX_W-1:0] idx, logic [DELIM_W-1:0] v);
    plan_row_t row;
    row          = '{default: '0};
    row.is_write = 1'b1;
    row.reg_idx  = idx;
    row.wdata    = v;
    return row;
  endfunction

  function automatic plan_row_t row_byte(logic [BYTE_W-1:0] b, bit l);
    plan_row_t row;
    row      = '{default: '0};
    row.data = b;
    row.last = l;
    return row;
  endfunction

  function automatic plan_row_t row_byte_chk(logic [BYTE_W-1:0] b, bit l, result_t want);
    plan_row_t row;
    row       = row_byte(b, l);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  // one beat on the input side, with random gaps before it unless no_gaps is set
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic l, input bit typed,
                           input result_t want);
    result_t guess;
    bit      produced;
    if (!no_gaps) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    produced = predict_segment(b, l, guess);
    if (typed) segments_due.push_back(want);
    else if (produced) segments_due.push_back(guess);
    beats_sent++;
  endtask

  // register write once the splitter has gone quiet
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELIM_W-1:0] v);
    in_tvalid <= 1'b0;
    while (segments_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELIM_BYTES: delim_word    = v;
      CFG_DELIM_LEN:   delim_len_reg = v[LEN_W-1:0];
      CFG_MAX_SEGS:    seg_limit     = v[SEG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pending();
    for (int i = 0; i < pending_bytes.size(); i++)
      send_beat(pending_bytes[i], i == pending_bytes.size() - 1, 1'b0, '0);
  endtask

  // random delimiter, length and segment limit, with junk in the unused bits
  task automatic config_random();
    int                 mode;
    int                 r;
    logic [DELIM_W-1:0] w;
    logic [DELIM_W-1:0] v;
    logic [BYTE_W-1:0]  fill;
    mode = $urandom_range(2);
    w    = {$urandom, $urandom};
    if (mode == 1) begin
      fill = BYTE_W'($urandom);
      w    = {8{fill}};
    end else if (mode == 2) begin
      for (int k = 0; k < 8; k++) w[8*k +: 8] = $urandom_range(1) ? 8'h41 : 8'h42;
    end
    write_reg(CFG_DELIM_BYTES, w);
    v = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 75) v[LEN_W-1:0] = LEN_W'($urandom_range(1, 8));
    else if (r < 85) v[LEN_W-1:0] = '0;
    else v[LEN_W-1:0] = LEN_W'($urandom_range(9, 15));
    write_reg(CFG_DELIM_LEN, v);
    v = {$urandom, $urandom};
    r = $urandom_range(99);
    if (r < 60) v[SEG_W-1:0] = '1;
    else if (r < 85) v[SEG_W-1:0] = SEG_W'($urandom_range(0, 4));
    write_reg(CFG_MAX_SEGS, v);
    if ($urandom_range(9) == 0) write_reg(CFG_SPARE, {$urandom, $urandom});
  endtask

  // mostly delimiter-rich buffers, some plain noise
  task automatic build_random_buffer();
    int target;
    int len;
    int r;
    int n;
    pending_bytes.delete();
    len = delim_len_used();
    if ($urandom_range(99) < 15) begin
      target = $urandom_range(1, 12);
      repeat (target) pending_bytes.push_back(BYTE_W'($urandom));
    end else begin
      target = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 40);
      while (pending_bytes.size() < target) begin
        r = $urandom_range(99);
        if (r < 30) begin
          for (int k = 0; k < len; k++) pending_bytes.push_back(delim_word[8*k +: 8]);
        end else if (r < 45) begin
          n = $urandom_range(0, len - 1);
          for (int k = 0; k < n; k++) pending_bytes.push_back(delim_word[8*k +: 8]);
        end else if (r < 75) begin
          pending_bytes.push_back(delim_word[8*$urandom_range(0, len - 1) +: 8]);
        end else begin
          pending_bytes.push_back(BYTE_W'($urandom));
        end
      end
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // result side stalls
  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
  end

  // compare every result beat with the oldest expected one
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (segments_due.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = segments_due.pop_front();
        check_field("segment_valid", int'(want.segment_valid), int'(out_tuser));
        check_field("segment_index", int'(want.segment_index), int'(out_tdata[15:0]));
        check_field("segment_start", int'(want.segment_start), int'(out_tdata[31:16]));
        check_field("segment_end", int'(want.segment_end), int'(out_tdata[48:32]));
        check_field("done_res", int'(want.done_res), int'(out_tlast));
        check_field("failed", int'(want.failed), int'(out_tdata[49]));
        check_field("segment_count", int'(want.segment_count), int'(out_tdata[65:50]));
      end
    end
  end

  initial begin
    plan_row_t plan[$];
    int        random_start;
    int        random_goal;
    int        bufs;

    delim_word    = DELIM_BYTES_RST;
    delim_len_reg = DELIM_LEN_RST;
    seg_limit     = MAX_SEGS_RST;
    reset_buffer_state();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    // reset delimiter is one zero byte: empty first segment, open tail
    plan.push_back(row_byte_chk(8'h00, 1'b0, make_res(1, 0, 0, 0, 0, 0, 0)));
    plan.push_back(row_byte_chk(8'hFF, 1'b1, make_res(1, 1, 1, 2, 1, 0, 2)));
    // delimiter ending the buffer leaves no trailing segment
    plan.push_back(row_byte_chk(8'h00, 1'b1, make_res(1, 0, 0, 0, 1, 0, 1)));
    // length zero acts as one byte
    plan.push_back(row_write(CFG_DELIM_BYTES, 64'hFFEE_DDCC_BBAA_9988));
    plan.push_back(row_write(CFG_DELIM_LEN, 64'hF0));
    plan.push_back(row_byte_chk(8'h88, 1'b0, make_res(1, 0, 0, 0, 0, 0, 0)));
    plan.push_back(row_byte_chk(8'h88, 1'b0, make_res(1, 1, 1, 1, 0, 0, 0)));
    plan.push_back(row_byte_chk(8'h12, 1'b1, make_res(1, 2, 2, 3, 1, 0, 3)));
    // length fifteen clamps to the full eight byte delimiter
    plan.push_back(row_write(CFG_DELIM_LEN, 64'hF));
    plan.push_back(row_byte(8'h01, 1'b0));
    plan.push_back(row_byte(8'h88, 1'b0));
    plan.push_back(row_byte(8'h99, 1'b0));
    plan.push_back(row_byte(8'hAA, 1'b0));
    plan.push_back(row_byte(8'hBB, 1'b0));
    plan.push_back(row_byte(8'hCC, 1'b0));
    plan.push_back(row_byte(8'hDD, 1'b0));
    plan.push_back(row_byte(8'hEE, 1'b0));
    plan.push_back(row_byte_chk(8'hFF, 1'b0, make_res(1, 0, 0, 1, 0, 0, 0)));
    plan.push_back(row_byte_chk(8'h55, 1'b1, make_res(1, 1, 9, 10, 1, 0, 2)));
    // no segments allowed at all
    plan.push_back(row_write(CFG_MAX_SEGS, 64'hFFFF_FFFF_FFFF_0000));
    plan.push_back(row_byte_chk(8'h42, 1'b1, make_res(0, 0, 0, 0, 1, 1, 0)));
    // two byte delimiter, one segment allowed, bytes left over
    plan.push_back(row_write(CFG_MAX_SEGS, 64'h1));
    plan.push_back(row_write(CFG_DELIM_LEN, 64'h2));
    plan.push_back(row_write(CFG_DELIM_BYTES, 64'h0A0D));
    plan.push_back(row_byte(8'h61, 1'b0));
    plan.push_back(row_byte(8'h0D, 1'b0));
    plan.push_back(row_byte_chk(8'h0A, 1'b0, make_res(1, 0, 0, 1, 0, 0, 0)));
    plan.push_back(row_byte(8'h62, 1'b0));
    plan.push_back(row_byte_chk(8'h63, 1'b1, make_res(0, 0, 0, 0, 1, 1, 1)));
    plan.push_back(row_write(CFG_SPARE, 64'hDEAD_BEEF_0123_4567));
    foreach (plan[i]) begin
      if (plan[i].is_write) write_reg(plan[i].reg_idx, plan[i].wdata);
      else send_beat(plan[i].data, plan[i].last, plan[i].typed, plan[i].want);
    end

    // random settings, a handful of buffers each
    random_start = beats_sent;
    random_goal  = random_start + RANDOM_BEATS;
    while (beats_sent < random_goal) begin
      // a stretch in the middle runs with no idle cycles on either side
      no_gaps = (beats_sent >= random_start + GAPLESS_FROM) &&
                (beats_sent < random_start + GAPLESS_TO);
      config_random();
      bufs = $urandom_range(3, 8);
      repeat (bufs) begin
        build_random_buffer();
        send_pending();
      end
    end
    no_gaps = 1'b0;
    in_tvalid <= 1'b0;

    while (segments_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("testbench failed");
    $finish;
  end

endmodule

[filelist.f]
design/mbds_pkg.sv
design/mbds_in_stage.sv
design/mbds_core.sv
design/multi_byte_delimiter_splitter.sv
tb/testbench.sv
